### hdl/smf16_pkg.sv
// smf16_pkg: fp16 constants and lane compare helpers for the segment max block
// no dependencies
`timescale 1ns / 1ps
package smf16_pkg;
    localparam logic [15:0] FP16_EXP_MASK = 16'h7c00;
    localparam logic [15:0] FP16_MAN_MASK = 16'h03ff;
    localparam logic [15:0] FP16_NEG_INF  = 16'hfc00;
    localparam int          MAX_LANES     = 4;

    typedef logic [15:0] fp16_t;

    function automatic logic is_nan16(input fp16_t b);
        is_nan16 = ((b & FP16_EXP_MASK) == FP16_EXP_MASK) && ((b & FP16_MAN_MASK) != 16'h0000);
    endfunction

    function automatic logic [15:0] order_key(input fp16_t b);
        order_key = b[15] ? ~b : (b | 16'h8000);
    endfunction
endpackage

### hdl/smf16_lane.sv
// smf16_lane: one lane of running fp16 max with nan hold
// depends on smf16_pkg
`timescale 1ns / 1ps
module smf16_lane
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 step,
    input  logic                 clear,
    input  logic                 nan_propagate,
    input  smf16_pkg::fp16_t     din,
    output smf16_pkg::fp16_t     upd
);
    smf16_pkg::fp16_t max_reg;
    smf16_pkg::fp16_t max_next;
    logic             held_reg;
    logic             held_next;

    always_comb
    begin
        max_next  = max_reg;
        held_next = held_reg;
        if (smf16_pkg::is_nan16(din))
        begin
            if (nan_propagate)
            begin
                max_next  = din;
                held_next = 1'b1;
            end
        end
        else if (!held_reg &&
                 smf16_pkg::order_key(din) > smf16_pkg::order_key(max_reg))
        begin
            max_next = din;
        end
    end

    assign upd = max_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_reg  <= smf16_pkg::FP16_NEG_INF;
            held_reg <= 1'b0;
        end
        else if (clear)
        begin
            max_reg  <= smf16_pkg::FP16_NEG_INF;
            held_reg <= 1'b0;
        end
        else if (step)
        begin
            max_reg  <= max_next;
            held_reg <= held_next;
        end
    end
endmodule

### hdl/segment_max_fp16_lanes_top.sv
// segment_max_fp16_lanes_top: four-lane fp16 segment max with apb register port
// depends on smf16_pkg and smf16_lane
`timescale 1ns / 1ps
// usage:
//   input beats carry four fp16 lanes plus last_neighbor and empty_segment.
//   each lane keeps a running max from minus infinity; a beat with
//   last_neighbor emits the lane maxima, a beat with empty_segment emits
//   zeros; both return the lanes to minus infinity.
//   one beat is taken every cycle while in_stall is low; a result appears in
//   the cycle after the beat that closes the segment, held in an output register.
//   the input is stalled only while a result waits and the receiver stalls;
//   a non-closing beat is still taken in that case.
//   register 0 at address 0: bit 0 nan_propagate, reset 1.
//   reset clears the lanes, nan holds and the output valid.
//   lanes at or above LANES are ignored and read zero.
//   per-lane compare and select sets the one cycle rate.
module segment_max_fp16_lanes_top
#(
    parameter int LANES = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic        paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [15:0] lane_a,
    input  logic [15:0] lane_b,
    input  logic [15:0] lane_c,
    input  logic [15:0] lane_d,
    input  logic        last_neighbor,
    input  logic        empty_segment,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] max_a,
    output logic [15:0] max_b,
    output logic [15:0] max_c,
    output logic [15:0] max_d
);
    logic             nanp_reg;
    logic             out_valid_reg;
    smf16_pkg::fp16_t res_reg  [smf16_pkg::MAX_LANES];
    smf16_pkg::fp16_t res_next [smf16_pkg::MAX_LANES];
    smf16_pkg::fp16_t din      [smf16_pkg::MAX_LANES];
    smf16_pkg::fp16_t upd      [smf16_pkg::MAX_LANES];
    logic             acc;
    logic             closing;
    logic             emit_blocked;

    assign pready = 1'b1;
    assign prdata = {31'b0, nanp_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            nanp_reg <= 1'b1;
        else if (psel && penable && pwrite && !paddr)
            nanp_reg <= pwdata[0];
    end

    assign closing      = last_neighbor || empty_segment;
    assign emit_blocked = out_valid_reg && out_stall;
    assign in_stall     = emit_blocked && closing;
    assign acc          = in_valid && !in_stall;

    assign din[0] = lane_a;
    assign din[1] = lane_b;
    assign din[2] = lane_c;
    assign din[3] = lane_d;

    genvar g;
    generate
        for (g = 0; g < smf16_pkg::MAX_LANES; g++)
        begin : g_lane
            if (g < LANES)
            begin : g_on
                smf16_lane u_lane
                (
                    .clk           (clk),
                    .rst_n         (rst_n),
                    .step          (acc && !empty_segment),
                    .clear         (acc && closing),
                    .nan_propagate (nanp_reg),
                    .din           (din[g]),
                    .upd           (upd[g])
                );
                assign res_next[g] = empty_segment ? 16'h0000 : upd[g];
            end
            else
            begin : g_off
                assign upd[g]      = 16'h0000;
                assign res_next[g] = upd[g];
            end
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (acc && closing)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (acc && closing)
            res_reg <= res_next;
    end

    assign out_valid = out_valid_reg;
    assign max_a     = res_reg[0];
    assign max_b     = res_reg[1];
    assign max_c     = res_reg[2];
    assign max_d     = res_reg[3];
endmodule
